### rtl/mss_pkg.sv
`default_nettype none
package mss_pkg;

  localparam int NUM_POSITIONS = 1024;
  localparam int VALUE_BITS    = 16;
  localparam int SUM_BITS      = 26;
  localparam int POS_BITS      = 11;
  localparam int NODE_COUNT    = 2 * NUM_POSITIONS;
  localparam int NODE_AW       = $clog2(NODE_COUNT);

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_BADPOS = 2'd2;

  typedef struct packed {
    logic                       emp;
    logic signed [SUM_BITS-1:0] tot;
    logic signed [SUM_BITS-1:0] pre;
    logic signed [SUM_BITS-1:0] suf;
    logic signed [SUM_BITS-1:0] bst;
  } node_t;

  localparam int NODE_BITS = $bits(node_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_LEAF,
    ST_U_RD,
    ST_U_CMB,
    ST_Q_LO,
    ST_Q_LOW,
    ST_Q_HI,
    ST_Q_HIW,
    ST_Q_FIN,
    ST_OUT
  } state_t;

  function automatic node_t empty_node();
    node_t n;
    n     = '0;
    n.emp = 1'b1;
    return n;
  endfunction

  // Combine of a left span and the span right of it; empty is the identity.
  function automatic node_t join_nodes(input node_t a, input node_t b);
    node_t r;
    logic signed [SUM_BITS-1:0] t1;
    logic signed [SUM_BITS-1:0] t2;
    logic signed [SUM_BITS-1:0] t3;
    logic signed [SUM_BITS-1:0] mb;
    t1    = a.tot + b.pre;
    t2    = a.suf + b.tot;
    t3    = a.suf + b.pre;
    mb    = (a.bst > b.bst) ? a.bst : b.bst;
    r.emp = 1'b0;
    r.tot = a.tot + b.tot;
    r.pre = (a.pre > t1) ? a.pre : t1;
    r.suf = (b.suf > t2) ? b.suf : t2;
    r.bst = (t3 > mb) ? t3 : mb;
    if (a.emp) begin
      r = b;
    end else if (b.emp) begin
      r = a;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/mss_ram.sv
`default_nettype none
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/max_subarray_segment_tree.sv
`default_nettype none
// Channel  Direction  Handshake             Word
// input    in         in_valid / in_ready   cmd, pos_a, pos_b, new_value
// output   out        out_valid / out_ready best_sum, status
//
// An update does one read of the sibling and one combine-and-write of the parent
// per tree level, through the single node memory. A query walks up the tree from
// both ends of its range, reading and joining nodes through the same memory.
// After reset a clearing pass writes the empty node to all 2*N entries with
// in_ready low. Results wait in an output register, so a new word is taken while
// an old result stalls; a query only stalls at its end.
module max_subarray_segment_tree
  import mss_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         cmd,
  input  wire logic [POS_BITS-1:0]          pos_a,
  input  wire logic [POS_BITS-1:0]          pos_b,
  input  wire logic signed [VALUE_BITS-1:0] new_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [SUM_BITS-1:0]        best_sum,
  output logic [1:0]                        status
);

  localparam int PW = (POS_BITS > NODE_AW + 1) ? POS_BITS : NODE_AW + 1;

  state_t state, state_next;

  logic [NODE_AW-1:0] clr_idx;
  logic [NODE_AW-1:0] idx;
  logic [NODE_AW:0]   lo;
  logic [NODE_AW:0]   hi;
  node_t              cur;
  node_t              left;
  node_t              right;
  node_t              rnode;
  node_t              parent;
  node_t              all_q;
  logic signed [SUM_BITS-1:0] res_sum;
  logic [1:0]         res_status;

  logic               we;
  logic [NODE_AW-1:0] waddr;
  node_t              wdata;
  logic [NODE_AW-1:0] raddr;
  logic [NODE_BITS-1:0] rdata;

  logic               accept;
  logic               slot_free;
  logic               a_ok;
  logic               b_ok;
  logic [PW-1:0]      pa;
  logic [PW-1:0]      pb;
  logic [PW-1:0]      pmin;
  logic [PW-1:0]      pmax;

  mss_ram #(
    .WIDTH(NODE_BITS),
    .DEPTH(NODE_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rnode     = node_t'(rdata);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign pa        = PW'(pos_a);
  assign pb        = PW'(pos_b);
  assign a_ok      = (pa != '0) && (pa <= PW'(NUM_POSITIONS));
  assign b_ok      = (pb != '0) && (pb <= PW'(NUM_POSITIONS));
  assign pmin      = (pa > pb) ? pb : pa;
  assign pmax      = (pa > pb) ? pa : pb;
  // On the path up, the node held in cur is the left child when idx is even.
  assign parent    = idx[0] ? join_nodes(rnode, cur) : join_nodes(cur, rnode);
  assign all_q     = join_nodes(left, right);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_idx == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_UPDATE) begin
            state_next = a_ok ? ST_U_LEAF : ST_IDLE;
          end else begin
            state_next = (a_ok && b_ok) ? ST_Q_LO : ST_OUT;
          end
        end
      end
      ST_U_LEAF: state_next = ST_U_RD;
      ST_U_RD:   state_next = (idx == NODE_AW'(1)) ? ST_IDLE : ST_U_CMB;
      ST_U_CMB:  state_next = ST_U_RD;
      ST_Q_LO: begin
        if (lo >= hi) begin
          state_next = ST_Q_FIN;
        end else begin
          state_next = lo[0] ? ST_Q_LOW : ST_Q_HI;
        end
      end
      ST_Q_LOW: state_next = ST_Q_HI;
      ST_Q_HI:  state_next = hi[0] ? ST_Q_HIW : ST_Q_LO;
      ST_Q_HIW: state_next = ST_Q_LO;
      ST_Q_FIN: state_next = ST_OUT;
      ST_OUT:   if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    we       = 1'b0;
    waddr    = idx;
    wdata    = cur;
    raddr    = idx ^ NODE_AW'(1);
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_idx;
        wdata = empty_node();
      end
      ST_IDLE:   in_ready = 1'b1;
      ST_U_LEAF: we = 1'b1;
      ST_U_CMB: begin
        we    = 1'b1;
        waddr = idx >> 1;
        wdata = parent;
      end
      ST_Q_LO: raddr = lo[NODE_AW-1:0];
      ST_Q_HI: raddr = hi[NODE_AW-1:0] - NODE_AW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + NODE_AW'(1);
      end
      if (state == ST_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur.emp    <= 1'b0;
        cur.tot    <= SUM_BITS'(new_value);
        cur.pre    <= SUM_BITS'(new_value);
        cur.suf    <= SUM_BITS'(new_value);
        cur.bst    <= SUM_BITS'(new_value);
        idx        <= NODE_AW'(pa + PW'(NUM_POSITIONS - 1));
        lo         <= (NODE_AW + 1)'(pmin + PW'(NUM_POSITIONS - 1));
        hi         <= (NODE_AW + 1)'(pmax + PW'(NUM_POSITIONS));
        left       <= empty_node();
        right      <= empty_node();
        res_sum    <= '0;
        res_status <= STAT_BADPOS;
      end
      ST_U_CMB: begin
        cur <= parent;
        idx <= idx >> 1;
      end
      ST_Q_LOW: begin
        left <= join_nodes(left, rnode);
        lo   <= lo + (NODE_AW + 1)'(1);
      end
      ST_Q_HI: begin
        if (hi[0]) begin
          hi <= hi - (NODE_AW + 1)'(1);
        end else begin
          lo <= lo >> 1;
          hi <= hi >> 1;
        end
      end
      ST_Q_HIW: begin
        right <= join_nodes(rnode, right);
        lo    <= lo >> 1;
        hi    <= hi >> 1;
      end
      ST_Q_FIN: begin
        // Node sums span at most N values of VALUE_BITS, so they never
        // leave the SUM_BITS range and no clamp is needed.
        res_sum    <= all_q.emp ? '0 : all_q.bst;
        res_status <= all_q.emp ? STAT_EMPTY : STAT_OK;
      end
      ST_OUT: begin
        if (slot_free) begin
          best_sum <= res_sum;
          status   <= res_status;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
